/* design/efi_pkg.sv */
// Shared types and constants for the escape-time fractal iterator.
`default_nettype none
package efi_pkg;

    localparam int unsigned FRAC_BITS = 28;
    localparam int unsigned IDX_W     = 5;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_CONST_RE = 2'd1;
    localparam logic [1:0] REG_CONST_IM = 2'd2;

    localparam logic MODE_MANDEL = 1'b0;
    localparam logic MODE_JULIA  = 1'b1;

    // |z|^2 limits in Q8.56
    localparam logic [63:0] LIMIT_MANDEL = 64'h0500_0000_0000_0000;
    localparam logic [63:0] LIMIT_JULIA  = 64'h0400_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
    } dp_sts_t;

    // clamp a 37-bit signed sum to the Q4.28 range
    function automatic logic signed [31:0] sat_q428(input logic signed [36:0] x);
        logic signed [36:0] hi;
        logic signed [36:0] lo;
        hi = 37'sh0_7FFF_FFFF;
        lo = -37'sh0_8000_0000;
        if (x > hi)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (x < lo)
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return x[31:0];
        end
    endfunction

endpackage
`default_nettype wire

/* design/efi_dp.sv */
// Datapath: z registers, squaring products, update, saturation and escape test.
`default_nettype none
module efi_dp
    import efi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [31:0] point_re,
    input  wire logic [31:0] point_im,
    input  wire dp_cmd_t     cmd,
    output dp_sts_t          sts
);

    logic               mode_reg;
    logic signed [31:0] jre_reg;
    logic signed [31:0] jim_reg;

    logic signed [31:0] z_re_reg;
    logic signed [31:0] z_im_reg;
    logic signed [31:0] c_re_reg;
    logic signed [31:0] c_im_reg;
    logic               julia_reg;
    logic signed [63:0] rr_reg;
    logic signed [63:0] ii_reg;
    logic signed [63:0] ri_reg;

    logic signed [63:0] diff;
    logic signed [35:0] re_sh;
    logic signed [36:0] im_sh;
    logic signed [36:0] re_sum;
    logic signed [36:0] im_sum;
    logic        [63:0] mag;
    logic        [63:0] limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MANDEL;
            jre_reg  <= '0;
            jim_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg <= cfg_data[0];
                REG_CONST_RE: jre_reg  <= cfg_data;
                REG_CONST_IM: jim_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        diff   = rr_reg - ii_reg;
        re_sh  = 36'(diff >>> FRAC_BITS);
        im_sh  = 37'(ri_reg >>> (FRAC_BITS - 1));
        re_sum = 37'(re_sh) + 37'(c_re_reg);
        im_sum = im_sh + 37'(c_im_reg);
        mag    = $unsigned(rr_reg) + $unsigned(ii_reg);
        limit  = julia_reg ? LIMIT_JULIA : LIMIT_MANDEL;
        sts.hit = mag > limit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_re_reg  <= point_re;
            z_im_reg  <= point_im;
            julia_reg <= mode_reg;
            c_re_reg  <= mode_reg ? jre_reg : point_re;
            c_im_reg  <= mode_reg ? jim_reg : point_im;
        end
        else if (cmd.upd)
        begin
            z_re_reg <= sat_q428(re_sum);
            z_im_reg <= sat_q428(im_sum);
        end
        if (cmd.mul)
        begin
            rr_reg <= z_re_reg * z_re_reg;
            ii_reg <= z_im_reg * z_im_reg;
            ri_reg <= z_re_reg * z_im_reg;
        end
    end

endmodule
`default_nettype wire

/* design/efi_ctrl.sv */
// Controller: iteration sequencing, counter and result word register.
`default_nettype none
module efi_ctrl
    import efi_pkg::*;
#(
    parameter int unsigned MAX_ITER = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             out_escaped,
    output logic [IDX_W-1:0] out_index,
    output dp_cmd_t          cmd,
    input  wire dp_sts_t     sts
);

    localparam int unsigned CW = $clog2(MAX_ITER + 1);
    localparam int unsigned IW = (CW > IDX_W) ? CW : IDX_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     k_reg, k_next;
    logic              res_esc_reg, res_esc_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_esc_reg, out_esc_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;

    logic              s_accept;
    logic              slot_free;
    logic              escape;
    logic              finish;
    logic [IW-1:0]     k_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_esc_reg <= res_esc_next;
        res_idx_reg <= res_idx_next;
        out_esc_reg <= out_esc_next;
        out_idx_reg <= out_idx_next;
    end

    always_comb
    begin
        s_accept  = s_tvalid && (state_reg == ST_IDLE);
        slot_free = !out_valid_reg || m_tready;
        escape    = (k_reg != '0) && sts.hit;
        finish    = escape || (k_reg == CW'(MAX_ITER));
        k_m1      = IW'(k_reg) - IW'(1);

        state_next     = state_reg;
        k_next         = k_reg;
        res_esc_next   = res_esc_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_esc_next   = out_esc_reg;
        out_idx_next   = out_idx_reg;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd.load   = 1'b1;
                    k_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (finish)
                begin
                    res_esc_next = escape;
                    if (!escape)
                    begin
                        res_idx_next = '0;
                    end
                    else if (k_m1 > IW'(31))
                    begin
                        res_idx_next = '1;
                    end
                    else
                    begin
                        res_idx_next = k_m1[IDX_W-1:0];
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.upd    = 1'b1;
                    k_next     = k_reg + CW'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_esc_next   = res_esc_reg;
                    out_idx_next   = res_idx_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign out_escaped = out_esc_reg;
    assign out_index   = out_idx_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= CW'(MAX_ITER))
        else $error("iteration count beyond limit");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_MUL) && (k_reg == '0))
        else $error("load did not start iteration");

    a_done_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && slot_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not handed to output");

    a_no_idle_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) && (k_reg == '0) |=> state_reg == ST_MUL)
        else $error("escape tested before first update");

endmodule
`default_nettype wire

/* design/escape_time_fractal_iterator_unit.sv */
// Top level of the escape-time fractal iterator (Mandelbrot / Julia).
//
// Input stream s_*: one word per point, s_tdata = {point_im, point_re}, both
// signed Q4.28. Output stream m_*: one word per point, m_tdata bit 0 is
// escaped, bits 5:1 the zero-based escape iteration (0 when not escaped).
// Config channel cfg_*: index 0 mode (0 Mandelbrot, 1 Julia), 1 and 2 the
// Julia constant real / imaginary parts; always ready, write only when idle.
// Each iteration runs a multiply state on the shared multiplier set (three
// 32x32 products), then an update state for update, saturation and the
// |z|^2 test. One point is processed at a time; s_tready is high only while
// the iterator is idle. The result sits in an output register, so a new
// point is accepted while the previous word waits; if the receiver still
// holds off when the next result is ready, the iterator waits with it. Reset
// clears the controller, the output valid and the config registers
// (Mandelbrot, constant zero).
`default_nettype none
module escape_time_fractal_iterator_unit
    import efi_pkg::*;
#(
    parameter int unsigned MAX_ITER = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // point_re[31:0], point_im[63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // escaped[0], escape_index[5:1], zero[7:6]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic             escaped;
    logic [IDX_W-1:0] escape_index;

    assign cfg_ready = 1'b1;

    efi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_re  (s_tdata[31:0]),
        .point_im  (s_tdata[63:32]),
        .cmd       (cmd),
        .sts       (sts)
    );

    efi_ctrl #(
        .MAX_ITER (MAX_ITER)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_escaped (escaped),
        .out_index   (escape_index),
        .cmd         (cmd),
        .sts         (sts)
    );

    assign m_tdata = {2'b00, escape_index, escaped};

endmodule
`default_nettype wire

/* sim/escape_time_fractal_iterator_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench for the escape-time fractal iterator, both modes.
module escape_time_fractal_iterator_unit_tb;
    import efi_pkg::*;

    localparam int unsigned ITER_LIMIT = 32;
    localparam int          Q_ONE      = 268435456;
    localparam logic [1:0]  REG_UNUSED = 2'd3;
    localparam logic signed [63:0] Q_HI = 64'sd2147483647;
    localparam logic signed [63:0] Q_LO = -64'sd2147483648;

    typedef struct packed {
        logic             escaped;
        logic [IDX_W-1:0] escape_index;
    } escape_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // point_re[31:0], point_im[63:32]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;     // escaped[0], escape_index[5:1], zero[7:6]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the block's registers
    logic               mode_shadow;
    logic signed [31:0] c_re_shadow;
    logic signed [31:0] c_im_shadow;

    escape_t escape_q[$];
    bit      idle_on   = 1'b1;
    int      hold_left = 0;
    int      errors    = 0;
    int      n_points  = 0;
    int      n_julia   = 0;
    int      n_escaped = 0;
    int      n_writes  = 0;

    escape_time_fractal_iterator_unit #(
        .MAX_ITER(ITER_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [63:0] clamp_q428(input logic signed [63:0] x);
        if (x > Q_HI)
            return Q_HI;
        if (x < Q_LO)
            return Q_LO;
        return x;
    endfunction

    function automatic escape_t escape_time(input logic signed [31:0] p_re,
                                            input logic signed [31:0] p_im);
        logic signed [63:0] zr;
        logic signed [63:0] zi;
        logic signed [63:0] cr;
        logic signed [63:0] ci;
        logic signed [63:0] sq_re;
        logic signed [63:0] sq_im;
        logic signed [63:0] sq_ri;
        logic [63:0]        mag;
        logic [63:0]        limit;
        escape_t            res;
        bit                 done;
        zr = p_re;
        zi = p_im;
        if (mode_shadow == MODE_JULIA)
        begin
            cr    = c_re_shadow;
            ci    = c_im_shadow;
            limit = LIMIT_JULIA;
        end
        else
        begin
            cr    = p_re;
            ci    = p_im;
            limit = LIMIT_MANDEL;
        end
        res  = '0;
        done = 1'b0;
        for (int k = 0; k < ITER_LIMIT; k++)
        begin
            if (!done)
            begin
                sq_re = zr * zr;
                sq_im = zi * zi;
                sq_ri = zr * zi;
                zr    = clamp_q428(((sq_re - sq_im) >>> FRAC_BITS) + cr);
                zi    = clamp_q428((sq_ri >>> (FRAC_BITS - 1)) + ci);
                mag   = $unsigned(zr * zr) + $unsigned(zi * zi);
                if (mag > limit)
                begin
                    done             = 1'b1;
                    res.escaped      = 1'b1;
                    res.escape_index = (k > 31) ? {IDX_W{1'b1}} : IDX_W'(k);
                end
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // mostly points near the interesting region, some noise and extremes
    task automatic random_point(output logic signed [31:0] re, output logic signed [31:0] im);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            if (mode_shadow == MODE_JULIA)
            begin
                re = int'($urandom_range(1073741824)) - 536870912;
                im = int'($urandom_range(1073741824)) - 536870912;
            end
            else
            begin
                re = int'($urandom_range(939524096)) - 671088640;
                im = int'($urandom_range(805306368)) - 402653184;
            end
        end
        else if (pick < 75)
        begin
            // near the set boundary: long runs
            re = -201326592 + int'($urandom_range(33554432)) - 16777216;
            im = 26843546 + int'($urandom_range(33554432)) - 16777216;
        end
        else if (pick < 90)
        begin
            re = $urandom();
            im = $urandom();
        end
        else
        begin
            re = edge_value();
            im = edge_value();
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE:     mode_shadow = data[0];
            REG_CONST_RE: c_re_shadow = data;
            REG_CONST_IM: c_im_shadow = data;
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
        while (idle_on && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        do @(posedge clk); while (!s_tready);
        escape_q.push_back(escape_time(re, im));
        n_points++;
        if (mode_shadow == MODE_JULIA)
            n_julia++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (escape_q.size() != 0)
            @(posedge clk);
        repeat (2 * ITER_LIMIT + 8) @(negedge clk);
    endtask

    task automatic set_julia(input logic signed [31:0] c_re, input logic signed [31:0] c_im);
        wait_idle();
        cfg_write(REG_MODE, ($urandom() & 32'hFFFF_FFFE) | MODE_JULIA);
        cfg_write(REG_CONST_RE, c_re);
        cfg_write(REG_CONST_IM, c_im);
    endtask

    // word acceptance on the result side
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= !(idle_on && $urandom_range(99) < 24);
    end

    always @(posedge clk)
    begin : check_results
        escape_t got;
        escape_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.escaped      = m_tdata[0];
            got.escape_index = m_tdata[5:1];
            if (escape_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result word %h", $realtime, m_tdata);
            end
            else
            begin
                want = escape_q.pop_front();
                n_escaped += got.escaped;
                if (got.escaped !== want.escaped || got.escape_index !== want.escape_index)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: mismatch: expected escaped=%0b index=%0d, got escaped=%0b index=%0d",
                                 $realtime, want.escaped, want.escape_index,
                                 got.escaped, got.escape_index);
                end
            end
        end
    end

    // default mode after reset, constants zero
    task automatic test_mandel_directed();
        send_point(0, 0);
        send_point(2 * Q_ONE, 0);
        send_point(-2 * Q_ONE, 0);          // sits on |z|^2 = 4, never escapes
        send_point(Q_ONE / 4, 0);
        send_point(69793218, 0);            // just outside the cusp, late escape
        send_point(-201326592, 26843546);
        send_point(0, Q_ONE);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 0);
        send_point(0, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_julia_directed();
        set_julia(0, 0);
        send_point(Q_ONE, 0);
        send_point(2 * Q_ONE, 0);
        send_point(0, 0);
        set_julia(2 * Q_ONE, 0);            // first step lands exactly on the limit
        send_point(0, 0);
        set_julia(-2 * Q_ONE, 0);
        send_point(0, 0);
        set_julia(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(0, 0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();
        cfg_write(REG_UNUSED, $urandom());  // must be ignored
        send_point(Q_ONE / 2, Q_ONE / 2);
    endtask

    task automatic test_mandel_random(input int count);
        logic signed [31:0] re;
        logic signed [31:0] im;
        wait_idle();
        cfg_write(REG_MODE, ($urandom() & 32'hFFFF_FFFE) | MODE_MANDEL);
        repeat (count)
        begin
            random_point(re, im);
            send_point(re, im);
        end
    endtask

    task automatic test_julia_random(input int per_const);
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic signed [31:0] c_re[6];
        logic signed [31:0] c_im[6];
        c_re = '{-214748365, 76504642, -107374182, -33554432, 0, 0};
        c_im = '{41875931, 2684355, 161061274, 184549376, 0, 0};
        c_re[4] = int'($urandom_range(536870912)) - 268435456;
        c_im[4] = int'($urandom_range(536870912)) - 268435456;
        c_re[5] = $urandom();
        c_im[5] = $urandom();
        for (int j = 0; j < 6; j++)
        begin
            set_julia(c_re[j], c_im[j]);
            repeat (per_const)
            begin
                random_point(re, im);
                send_point(re, im);
            end
        end
    endtask

    // result side stalls long enough for the input to back up
    task automatic test_backpressure();
        logic signed [31:0] re;
        logic signed [31:0] im;
        wait_idle();
        hold_left = 300;
        repeat (10)
        begin
            random_point(re, im);
            send_point(re, im);
        end
    endtask

    task automatic test_steady_stream(input int count);
        logic signed [31:0] re;
        logic signed [31:0] im;
        wait_idle();
        idle_on = 1'b0;
        repeat (count)
        begin
            random_point(re, im);
            send_point(re, im);
        end
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_MODE;
        cfg_data    = '0;
        mode_shadow = MODE_MANDEL;
        c_re_shadow = '0;
        c_im_shadow = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_mandel_directed();
        test_julia_directed();
        test_mandel_random(250);
        test_julia_random(40);
        test_backpressure();
        test_steady_stream(80);
        test_mandel_random(100);
        wait_idle();

        $display("Covered %0d points (%0d Julia, %0d Mandelbrot), %0d escaped, %0d register writes,",
                 n_points, n_julia, n_points - n_julia, n_escaped, n_writes);
        $display("with random stalls, a long output hold-off and a full-rate stretch.");
        if (errors == 0 && escape_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
